// ----- sv/tbrl_pkg.sv -----
package tbrl_pkg;

  // field and port widths
  localparam int TIME_W      = 63;
  localparam int BURST_W     = 16;
  localparam int RATE_W      = 32;
  localparam int TOK_W       = 32;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  // divide by 1e9: quotient estimate from the top bits, times floor(2^62 / 1e9)
  localparam int NS_W        = 30;
  localparam int DIV_SHIFT   = 30;
  localparam int RECIP_W     = 33;
  localparam int RECIP_SHIFT = 32;
  localparam logic [NS_W-1:0]    NS_PER_SEC = 30'd1000000000;
  localparam logic [RECIP_W-1:0] RECIP_1E9  = 33'd4611686018;
  localparam logic [31:0]        NS_X1      = 32'd1000000000;
  localparam logic [31:0]        NS_X2      = 32'd2000000000;
  localparam logic [31:0]        NS_X3      = 32'd3000000000;

  // reset values of the registers
  localparam logic [BURST_W-1:0] BURST_RST = 16'd10;
  localparam logic [RATE_W-1:0]  RATE_RST  = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BURST_SIZE  = 4'd0,
    CFG_REFILL_RATE = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    logic first;    // first event after reset: fill to burst size
    logic advance;  // time moved forward: refill and clamp
  } ev_flags_t;

endpackage

// ----- sv/tbrl_div1e9.sv -----
// Three-stage divide by 1e9: reciprocal estimate, back-multiply, small correction.
module tbrl_div1e9 #(
  parameter int IN_W = 40,
  parameter int SB_W = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [IN_W-1:0]            in_num,
  input  logic [SB_W-1:0]            in_sb,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [IN_W-30:0]           quo,
  output logic [tbrl_pkg::NS_W-1:0]  rem,
  output logic [SB_W-1:0]            out_sb
);

  localparam int HI_W   = IN_W - tbrl_pkg::DIV_SHIFT;
  localparam int Q_W    = IN_W - 29;
  localparam int PROD_W = HI_W + tbrl_pkg::RECIP_W;

  logic            v1, v2, v3;
  logic            rdy1, rdy2, rdy3;
  logic [IN_W-1:0] x1;
  logic [Q_W-1:0]  q1, q2;
  logic [SB_W-1:0] sb1, sb2;
  logic [31:0]     r2;
  logic [PROD_W-1:0] est;
  logic [31:0]     qm;
  logic [1:0]      cnt;
  logic [31:0]     sub;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;

  // estimate is low by at most three
  assign est = PROD_W'(in_num[IN_W-1:tbrl_pkg::DIV_SHIFT]) * PROD_W'(tbrl_pkg::RECIP_1E9);
  // remainder is below 4e9, so the low 32 bits are exact
  assign qm  = 32'(q1) * 32'(tbrl_pkg::NS_PER_SEC);

  always_comb begin
    priority if (r2 >= tbrl_pkg::NS_X3) begin
      cnt = 2'd3;
      sub = tbrl_pkg::NS_X3;
    end else if (r2 >= tbrl_pkg::NS_X2) begin
      cnt = 2'd2;
      sub = tbrl_pkg::NS_X2;
    end else if (r2 >= tbrl_pkg::NS_X1) begin
      cnt = 2'd1;
      sub = tbrl_pkg::NS_X1;
    end else begin
      cnt = 2'd0;
      sub = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1  <= in_num;
      q1  <= Q_W'(est >> tbrl_pkg::RECIP_SHIFT);
      sb1 <= in_sb;
    end
    if (rdy2) begin
      r2  <= x1[31:0] - qm;
      q2  <= q1;
      sb2 <= sb1;
    end
    if (rdy3) begin
      quo    <= q2 + Q_W'(cnt);
      rem    <= tbrl_pkg::NS_W'(r2 - sub);
      out_sb <= sb2;
    end
  end

endmodule

// ----- sv/tbrl_bucket.sv -----
// Refill saturation, then the bucket level update and result register.
module tbrl_bucket #(
  parameter int FRAC_BITS = 16,
  parameter int WR_W      = 43
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tbrl_pkg::ev_flags_t            flags,
  input  logic [WR_W-1:0]                wr,
  input  logic [tbrl_pkg::RATE_W-1:0]    q,
  input  logic [tbrl_pkg::BURST_W-1:0]   burst_size,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           allowed,
  output logic [tbrl_pkg::TOK_W-1:0]     tokens_left
);

  localparam int CAP_W = tbrl_pkg::BURST_W + FRAC_BITS;
  localparam int SUM_W = WR_W + 1;
  localparam int CMP_W = (SUM_W > CAP_W) ? SUM_W : CAP_W;

  logic                rdy_a, rdy_b;
  logic                va, vb;
  tbrl_pkg::ev_flags_t fl_a;
  logic [CAP_W-1:0]    add_a;
  logic [CAP_W-1:0]    cap;
  logic [CAP_W-1:0]    one;
  logic [SUM_W-1:0]    sum;
  logic [CAP_W-1:0]    add_c;
  logic [CAP_W:0]      lvl_sum;
  logic [CAP_W-1:0]    refilled;
  logic [CAP_W-1:0]    base;
  logic                pass;
  logic [CAP_W-1:0]    level_next;
  logic [CAP_W-1:0]    level;

  assign cap = CAP_W'(burst_size) << FRAC_BITS;
  assign one = CAP_W'(1) << FRAC_BITS;

  assign rdy_b     = !vb || out_ready;
  assign rdy_a     = !va || rdy_b;
  assign in_ready  = rdy_a;
  assign out_valid = vb;

  // whole seconds plus fraction, saturated at the cap
  assign sum   = SUM_W'(wr) + SUM_W'(q);
  assign add_c = (CMP_W'(sum) >= CMP_W'(cap)) ? cap : CAP_W'(sum);

  always_comb begin
    lvl_sum  = (CAP_W+1)'(level) + (CAP_W+1)'(add_a);
    refilled = (lvl_sum > (CAP_W+1)'(cap)) ? cap : CAP_W'(lvl_sum);
    priority if (fl_a.first) base = cap;
    else if (fl_a.advance)   base = refilled;
    else                     base = level;
    pass       = (base >= one);
    level_next = pass ? base - one : base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      vb    <= 1'b0;
      level <= '0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
      if (rdy_b && va) level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      fl_a  <= flags;
      add_a <= add_c;
    end
    if (rdy_b) begin
      allowed     <= pass;
      tokens_left <= tbrl_pkg::TOK_W'(level_next);
    end
  end

endmodule

// ----- sv/token_bucket_rate_limiter.sv -----
// channel    dir  handshake                 payload
// s_*        in   s_tvalid / s_tready       s_tdata: now_ns
// m_*        out  m_tvalid / m_tready       m_tdata: allowed, tokens_left
// cfg_*      in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One request per cycle while no full stage is stalled; a result passes through 10 register
// stages, the first loaded at the edge that takes its request.
// The two reciprocal-multiply divides by 1e9 take 3 stages each.
// Reset clears all stage valids and the bucket, and loads burst 10, rate 1.0/s.
// Every stage holds when the next one is full and stalled; empty stages close
// up, so requests keep entering while a result waits on m_tready.
module token_bucket_rate_limiter #(
  parameter int FRAC_BITS    = 16,
  parameter int ELAPSED_BITS = 40
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [tbrl_pkg::IN_TDATA_W-1:0]     s_tdata,   // [62:0] now_ns
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tbrl_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [0] allowed, [32:1] tokens_left
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbrl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int TIME_W = tbrl_pkg::TIME_W;
  localparam int EL_W   = ELAPSED_BITS;
  localparam int EQ_W   = EL_W - 29;
  localparam int WR_W   = EQ_W + tbrl_pkg::RATE_W;
  localparam int P_W    = tbrl_pkg::NS_W + tbrl_pkg::RATE_W;
  localparam int PQ_W   = P_W - 29;
  localparam int FL_W   = $bits(tbrl_pkg::ev_flags_t);
  localparam logic [TIME_W-1:0] EL_MAX = {TIME_W{1'b1}} >> (TIME_W - EL_W);

  logic [tbrl_pkg::BURST_W-1:0] burst_size;
  logic [tbrl_pkg::RATE_W-1:0]  refill_rate;

  // stage 1: time bookkeeping
  logic                 started;
  logic [TIME_W-1:0]    last_time;
  logic [TIME_W-1:0]    now;
  logic [TIME_W-1:0]    diff;
  logic                 later;
  logic                 v1, rdy1;
  logic [EL_W-1:0]      el1;
  tbrl_pkg::ev_flags_t  fl1;

  // elapsed / 1e9
  logic                 e_in_ready, e_valid, e_ready;
  logic [EQ_W-1:0]      e_quo;
  logic [tbrl_pkg::NS_W-1:0] e_rem;
  logic [FL_W-1:0]      e_sb;

  // multiply by rate
  logic                 v5, rdy5;
  logic [P_W-1:0]       p5;
  logic [WR_W-1:0]      wr5;
  tbrl_pkg::ev_flags_t  fl5;

  // fraction product / 1e9
  logic                 p_in_ready, p_valid, p_ready;
  logic [PQ_W-1:0]      p_quo;
  logic [FL_W+WR_W-1:0] p_sb;
  tbrl_pkg::ev_flags_t  p_fl;
  logic [WR_W-1:0]      p_wr;

  logic                 allowed;
  logic [tbrl_pkg::TOK_W-1:0] tokens_left;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_size  <= tbrl_pkg::BURST_RST;
      refill_rate <= tbrl_pkg::RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tbrl_pkg::CFG_BURST_SIZE:  burst_size  <= cfg_data[tbrl_pkg::BURST_W-1:0];
        tbrl_pkg::CFG_REFILL_RATE: refill_rate <= cfg_data[tbrl_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  assign now   = s_tdata[TIME_W-1:0];
  assign diff  = now - last_time;
  assign later = now > last_time;

  assign rdy1     = !v1 || e_in_ready;
  assign s_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      started   <= 1'b0;
      last_time <= '0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy1 && s_tvalid) begin
        started <= 1'b1;
        if (!started || later) last_time <= now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      fl1.first   <= !started;
      fl1.advance <= started && later;
      el1         <= (diff > EL_MAX) ? EL_W'(EL_MAX) : EL_W'(diff);
    end
  end

  tbrl_div1e9 #(
    .IN_W (EL_W),
    .SB_W (FL_W)
  ) u_div_el (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (e_in_ready),
    .in_num    (el1),
    .in_sb     (fl1),
    .out_valid (e_valid),
    .out_ready (e_ready),
    .quo       (e_quo),
    .rem       (e_rem),
    .out_sb    (e_sb)
  );

  assign rdy5    = !v5 || p_in_ready;
  assign e_ready = rdy5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (rdy5) begin
      v5 <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      p5  <= P_W'(e_rem) * P_W'(refill_rate);
      wr5 <= WR_W'(e_quo) * WR_W'(refill_rate);
      fl5 <= e_sb;
    end
  end

  tbrl_div1e9 #(
    .IN_W (P_W),
    .SB_W (FL_W + WR_W)
  ) u_div_frac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .in_ready  (p_in_ready),
    .in_num    (p5),
    .in_sb     ({fl5, wr5}),
    .out_valid (p_valid),
    .out_ready (p_ready),
    .quo       (p_quo),
    .rem       (),
    .out_sb    (p_sb)
  );

  assign p_fl = p_sb[FL_W+WR_W-1:WR_W];
  assign p_wr = p_sb[WR_W-1:0];

  tbrl_bucket #(
    .FRAC_BITS (FRAC_BITS),
    .WR_W      (WR_W)
  ) u_bucket (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (p_valid),
    .in_ready    (p_ready),
    .flags       (p_fl),
    .wr          (p_wr),
    .q           (tbrl_pkg::RATE_W'(p_quo)),
    .burst_size  (burst_size),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .allowed     (allowed),
    .tokens_left (tokens_left)
  );

  assign m_tdata = {7'd0, tokens_left, allowed};

endmodule

// ----- sv/tbrl_checker.sv -----
module tbrl_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [tbrl_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic [7:0] outstanding;
  logic       in_fire, out_fire;

  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 8'(in_fire) - 8'(out_fire);
    end
  end

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no result without an earlier request
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> outstanding != 8'd0)
    else $error("result with no pending request");

  // a dropped event leaves less than one whole token
  a_drop_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> (m_tdata[32:1] >> FRAC_BITS) == 32'd0)
    else $error("event dropped with a whole token present");

  // pipeline is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind token_bucket_rate_limiter tbrl_checker #(.FRAC_BITS(FRAC_BITS)) u_tbrl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAC_BITS    = 16;
  localparam int ELAPSED_BITS = 40;
  localparam int PIPE_LATENCY = 10;
  localparam int N_PHASES     = 8;
  localparam int PHASE_ITEMS  = 204;
  localparam int DRAIN_LIMIT  = 20000;

  localparam longint unsigned NS_PER_S    = 64'd1000000000;
  localparam logic [63:0]     ELAPSED_MAX = (64'd1 << ELAPSED_BITS) - 64'd1;
  localparam logic [63:0]     ONE_TOKEN   = 64'd1 << FRAC_BITS;

  // indexes past the two real registers; writes there must be dropped
  localparam logic [tbrl_pkg::CFG_IDX_W-1:0] CFG_SPARE_FIRST = 4'd2;
  localparam logic [tbrl_pkg::CFG_IDX_W-1:0] CFG_SPARE_LAST  = 4'd15;

  typedef struct packed {
    logic                       allowed;
    logic [tbrl_pkg::TOK_W-1:0] tokens_left;
  } verdict_t;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             s_tvalid  = 1'b0;
  logic                             s_tready;
  logic [tbrl_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                             m_tvalid;
  logic                             m_tready  = 1'b0;
  logic [tbrl_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [tbrl_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [tbrl_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  logic                   s_took    = 1'b0;
  int unsigned            send_idle_pct  = 0;
  int unsigned            recv_stall_pct = 0;
  int                     errors    = 0;

  logic [tbrl_pkg::TIME_W-1:0] pending_events[$];
  verdict_t                    expected_verdicts[$];
  logic [tbrl_pkg::TIME_W-1:0] stamp_hi = '0;  // latest event time handed to the driver

  // bucket shadow
  logic [tbrl_pkg::BURST_W-1:0] reg_burst  = tbrl_pkg::BURST_RST;
  logic [tbrl_pkg::RATE_W-1:0]  reg_rate   = tbrl_pkg::RATE_RST;
  logic [63:0]                  bkt_level  = '0;
  logic [tbrl_pkg::TIME_W-1:0]  bkt_stamp  = '0;
  logic                         bkt_primed = 1'b0;

  token_bucket_rate_limiter uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic verdict_t police_event(input logic [tbrl_pkg::TIME_W-1:0] now);
    logic [63:0]  cap;
    logic [63:0]  elapsed;
    logic [127:0] gain;
    verdict_t     v;
    cap = 64'(reg_burst) << FRAC_BITS;
    if (!bkt_primed) begin
      bkt_level  = cap;
      bkt_stamp  = now;
      bkt_primed = 1'b1;
    end else if (now > bkt_stamp) begin
      elapsed = 64'(now - bkt_stamp);
      if (elapsed > ELAPSED_MAX) elapsed = ELAPSED_MAX;
      // exact floor(elapsed * rate / 1e9), then saturate
      gain = (128'(elapsed) * 128'(reg_rate)) / 128'(NS_PER_S);
      if (gain > 128'(cap)) gain = 128'(cap);
      bkt_level = bkt_level + gain[63:0];
      if (bkt_level > cap) bkt_level = cap;
      bkt_stamp = now;
    end
    if (bkt_level >= ONE_TOKEN) begin
      bkt_level = bkt_level - ONE_TOKEN;
      v.allowed = 1'b1;
    end else begin
      v.allowed = 1'b0;
    end
    v.tokens_left = bkt_level[tbrl_pkg::TOK_W-1:0];
    return v;
  endfunction

  function automatic logic [tbrl_pkg::TIME_W-1:0] next_stamp();
    int unsigned                 pick;
    logic [63:0]                 wide;
    logic [tbrl_pkg::TIME_W-1:0] t;
    pick = $urandom_range(99);
    wide = {$urandom, $urandom};
    if (pick < 8) begin
      t = stamp_hi;
    end else if (pick < 15) begin
      t = wide[tbrl_pkg::TIME_W-1:0] % (stamp_hi + 63'd1);
    end else if (pick < 30) begin
      t = stamp_hi + 63'($urandom_range(2000000, 1));
    end else if (pick < 72) begin
      t = stamp_hi + 63'(wide[31:0]);
    end else if (pick < 82) begin
      t = stamp_hi + 63'(wide[ELAPSED_BITS-1:0]);
    end else if (pick < 88) begin
      // around the elapsed-time saturation point
      t = stamp_hi + 63'(ELAPSED_MAX) - 63'd2 + 63'($urandom_range(4));
    end else if (pick < 93) begin
      t = {1'b0, wide[61:0]};
    end else begin
      // whole seconds, one ns either side
      t = stamp_hi + 63'(NS_PER_S * $urandom_range(5, 1)) + 63'($urandom_range(2)) - 63'd1;
    end
    return t;
  endfunction

  task automatic send(input logic [tbrl_pkg::TIME_W-1:0] t);
    pending_events = {pending_events, t};
    if (t > stamp_hi) stamp_hi = t;
  endtask

  task automatic write_reg(input logic [tbrl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tbrl_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_requests();
    while (pending_events.size() != 0 || s_tvalid || expected_verdicts.size() != 0)
      @(posedge clk);
  endtask

  task automatic pick_settings();
    logic [tbrl_pkg::BURST_W-1:0] burst;
    logic [tbrl_pkg::RATE_W-1:0]  rate;
    case ($urandom_range(5))
      0: burst = '0;
      1: burst = 16'd1;
      2: burst = '1;
      5: burst = tbrl_pkg::BURST_W'($urandom);
      default: burst = tbrl_pkg::BURST_W'($urandom_range(16, 2));
    endcase
    case ($urandom_range(5))
      0: rate = '0;
      1: rate = '1;
      4: rate = tbrl_pkg::RATE_W'($urandom_range(65536, 1));
      5: rate = $urandom;
      default: rate = tbrl_pkg::RATE_W'($urandom_range(8 << FRAC_BITS, 1));
    endcase
    if ($urandom_range(1))
      write_reg(tbrl_pkg::CFG_IDX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
                $urandom);
    write_reg(tbrl_pkg::CFG_BURST_SIZE, tbrl_pkg::CFG_DATA_W'(burst));
    write_reg(tbrl_pkg::CFG_REFILL_RATE, rate);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_took) begin
      if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata  <= {1'b0, pending_events.pop_front()};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= $urandom_range(99) >= recv_stall_pct;
  end

  // monitor: shadow config, predict on each request, check each result
  always @(posedge clk) begin : monitor
    verdict_t want;
    verdict_t got;
    s_took <= s_tvalid && s_tready && !rst;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tbrl_pkg::CFG_BURST_SIZE)
          reg_burst = cfg_data[tbrl_pkg::BURST_W-1:0];
        else if (cfg_index == tbrl_pkg::CFG_REFILL_RATE)
          reg_rate = cfg_data[tbrl_pkg::RATE_W-1:0];
      end
      if (s_tvalid && s_tready)
        expected_verdicts = {expected_verdicts,
                             police_event(s_tdata[tbrl_pkg::TIME_W-1:0])};
      if (m_tvalid && m_tready) begin
        got.allowed     = m_tdata[0];
        got.tokens_left = m_tdata[tbrl_pkg::TOK_W:1];
        if (expected_verdicts.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got allowed=%0d tokens_left=%h",
                   $time, got.allowed, got.tokens_left);
        end else begin
          want = expected_verdicts.pop_front();
          if (got.allowed !== want.allowed) begin
            errors++;
            $display("%0t: allowed mismatch, expected %0d got %0d",
                     $time, want.allowed, got.allowed);
          end
          if (got.tokens_left !== want.tokens_left) begin
            errors++;
            $display("%0t: tokens_left mismatch, expected %h got %h",
                     $time, want.tokens_left, got.tokens_left);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("** token_bucket_rate_limiter: FAILED **");
    $finish;
  end

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: burst 10, 1 token/s
    send(63'd1000);                         // first event fills the bucket
    send(63'd1000);                         // same time, no refill
    send(63'd500);                          // time going backward
    send(63'd1000 + 63'd1500000000);        // 1.5 tokens back
    send(stamp_hi + (63'd1 << 41));         // gap beyond elapsed saturation
    send(63'd0);
    drain_requests();
    write_reg(tbrl_pkg::CFG_BURST_SIZE, 32'd1);   // cap below current level
    send(stamp_hi);                         // no clamp without time moving
    send(stamp_hi + 63'd1);                 // clamp now
    send(stamp_hi + 63'd1);
    drain_requests();
    write_reg(tbrl_pkg::CFG_BURST_SIZE, 32'd0);
    write_reg(tbrl_pkg::CFG_REFILL_RATE, '1);
    send(stamp_hi + 63'(NS_PER_S));         // zero burst drops everything
    send(stamp_hi + 63'd1);
    drain_requests();
    write_reg(tbrl_pkg::CFG_BURST_SIZE, 32'hFFFF);
    write_reg(CFG_SPARE_FIRST, '1);
    write_reg(CFG_SPARE_LAST, '0);
    send(stamp_hi + 63'(NS_PER_S));         // refill overflows the cap
    send(stamp_hi + (63'd1 << ELAPSED_BITS));
    drain_requests();
    write_reg(tbrl_pkg::CFG_REFILL_RATE, 32'd0);
    send(stamp_hi + 63'(NS_PER_S));
    send(stamp_hi);
    drain_requests();
    write_reg(tbrl_pkg::CFG_BURST_SIZE, 32'd3);
    write_reg(tbrl_pkg::CFG_REFILL_RATE, 32'd1);
    send(stamp_hi + 63'(ELAPSED_MAX));
    send(stamp_hi + 63'(3 * NS_PER_S));
    drain_requests();
    write_reg(tbrl_pkg::CFG_REFILL_RATE, 32'h0001_8000);
    send(stamp_hi + 63'd333333333);         // fractional refill truncates

    for (int p = 0; p < N_PHASES; p++) begin
      drain_requests();
      pick_settings();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      repeat (PHASE_ITEMS) send(next_stamp());
    end
    // top of the time range, then back below it
    send({tbrl_pkg::TIME_W{1'b1}});
    send(63'd1 << 62);

    waited = 0;
    while ((pending_events.size() != 0 || s_tvalid || expected_verdicts.size() != 0)
           && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (expected_verdicts.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, expected_verdicts.size());
    if (errors == 0 && expected_verdicts.size() == 0 && pending_events.size() == 0) begin
      $display("** token_bucket_rate_limiter: PASSED **");
    end else begin
      $display("** token_bucket_rate_limiter: FAILED **");
    end
    $finish;
  end

endmodule
